// ===== rtl/variable_record_stream_deframer_defines.svh =====
// Assertion macros for the record stream deframer.
// Included by variable_record_stream_deframer, which checks its own logic; needs clk and rst_n in scope.
`ifndef VARIABLE_RECORD_STREAM_DEFRAMER_DEFINES_SVH
`define VARIABLE_RECORD_STREAM_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define VRSD_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VRSD_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vrsd_pkg.sv =====
// Shared types and constants of the record stream deframer.
// No dependencies.
package vrsd_pkg;

    localparam int unsigned LEN_FIELD_BYTES = 4;
    localparam int unsigned ID_BYTES        = 16;
    localparam int unsigned ATTR_BYTES      = 4;

    localparam logic [2:0] KIND_NLEN = 3'd0;
    localparam logic [2:0] KIND_NAME = 3'd1;
    localparam logic [2:0] KIND_ID   = 3'd2;
    localparam logic [2:0] KIND_ATTR = 3'd3;
    localparam logic [2:0] KIND_DLEN = 3'd4;
    localparam logic [2:0] KIND_DATA = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    typedef enum logic [5:0] {
        FS_NLEN = 6'b000001,
        FS_NAME = 6'b000010,
        FS_ID   = 6'b000100,
        FS_ATTR = 6'b001000,
        FS_DLEN = 6'b010000,
        FS_DATA = 6'b100000
    } field_state_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [2:0]  field_kind;
        logic [31:0] field_byte_index;
        logic        record_end;
        logic [31:0] record_number;
        logic        buffer_end;
        logic [1:0]  parse_status;
    } result_t;

endpackage

// ===== rtl/variable_record_stream_deframer.sv =====
// Pipeline: an accepted byte goes through the input register, then the result register, which shows its result.
// Throughput: one byte per cycle unless out_stall holds a full output; the framing state update (field position
// counter and length bound compare) sits between the input register and the result register.
// Reset (rst_n, asynchronous): clears buffer_length, framing state, error flag and both
// valid flags. No clearing pass.
`include "variable_record_stream_deframer_defines.svh"

module variable_record_stream_deframer #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        cfg_write,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  byte_value,
    output logic [2:0]  field_kind,
    output logic [31:0] field_byte_index,
    output logic        record_end,
    output logic [31:0] record_number,
    output logic        buffer_end,
    output logic [1:0]  parse_status
);

    logic [31:0]        buffer_length_reg;
    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    vrsd_pkg::result_t  out_reg;
    vrsd_pkg::result_t  result;
    logic               advance;
    logic               take;

    assign advance        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_valid_reg && out_valid_reg && out_stall;
    assign take           = in_valid && !in_stall;
    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    vrsd_frame_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .commit        (advance),
        .item_byte     (in_byte_reg),
        .buffer_length (buffer_length_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg <= '0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                buffer_length_reg <= cfg_data;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_byte_reg <= in_byte;
        if (advance)
            out_reg <= result;
    end

    assign out_valid        = out_valid_reg;
    assign byte_value       = out_reg.byte_value;
    assign field_kind       = out_reg.field_kind;
    assign field_byte_index = out_reg.field_byte_index;
    assign record_end       = out_reg.record_end;
    assign record_number    = out_reg.record_number;
    assign buffer_end       = out_reg.buffer_end;
    assign parse_status     = out_reg.parse_status;

    `VRSD_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall, "input stalled with room")
    `VRSD_ASSERT_NOW(a_rec_end_kind, out_valid && record_end, field_kind == vrsd_pkg::KIND_DATA || field_kind == vrsd_pkg::KIND_DLEN, "record end outside data")
    `VRSD_ASSERT_NOW(a_open_end_error, out_valid && buffer_end && !record_end, parse_status == vrsd_pkg::STATUS_ERROR, "open record at buffer end")
    `VRSD_ASSERT_NOW(a_id_index, out_valid && field_kind == vrsd_pkg::KIND_ID, field_byte_index < 32'd16, "identifier index overrun")

endmodule

// ===== rtl/vrsd_frame_core.sv =====
// Framing state and per-byte classification of the record stream deframer.
// Depends on vrsd_pkg.
module vrsd_frame_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  commit,
    input  logic [7:0]            item_byte,
    input  logic [31:0]           buffer_length,
    output vrsd_pkg::result_t     result
);

    logic [31:0]              consumed_reg, consumed_next;
    vrsd_pkg::field_state_t   field_reg, field_next;
    logic [31:0]              pos_reg, pos_next;
    logic [LENGTH_BITS-1:0]   acc_reg, acc_next;
    logic [LENGTH_BITS-1:0]   name_len_reg, name_len_next;
    logic [31:0]              rec_cnt_reg, rec_cnt_next;
    logic                     err_reg, err_next;

    logic                     past_end;
    logic [31:0]              after;
    logic                     is_len;
    logic [31:0]              shifted;
    logic [31:0]              size;
    logic                     last;
    logic                     len_over;
    logic                     rec_end;
    logic                     buf_end;
    logic [2:0]               kind;
    vrsd_pkg::field_state_t   field_after;

    always_comb
    begin
        past_end = consumed_reg >= buffer_length;
        after    = consumed_reg + 32'd1;
        is_len   = (field_reg == vrsd_pkg::FS_NLEN) || (field_reg == vrsd_pkg::FS_DLEN);
        shifted  = 32'(item_byte) << {pos_reg[1:0], 3'b000};

        acc_next = acc_reg;
        if (is_len && pos_reg < 32'(vrsd_pkg::LEN_FIELD_BYTES))
        begin
            if (pos_reg == 32'd0)
                acc_next = shifted[LENGTH_BITS-1:0];
            else
                acc_next = acc_reg | shifted[LENGTH_BITS-1:0];
        end

        case (field_reg)
            vrsd_pkg::FS_NLEN:
            begin
                kind = vrsd_pkg::KIND_NLEN;
                size = 32'(vrsd_pkg::LEN_FIELD_BYTES);
            end
            vrsd_pkg::FS_NAME:
            begin
                kind = vrsd_pkg::KIND_NAME;
                size = 32'(name_len_reg);
            end
            vrsd_pkg::FS_ID:
            begin
                kind = vrsd_pkg::KIND_ID;
                size = 32'(vrsd_pkg::ID_BYTES);
            end
            vrsd_pkg::FS_ATTR:
            begin
                kind = vrsd_pkg::KIND_ATTR;
                size = 32'(vrsd_pkg::ATTR_BYTES);
            end
            vrsd_pkg::FS_DLEN:
            begin
                kind = vrsd_pkg::KIND_DLEN;
                size = 32'(vrsd_pkg::LEN_FIELD_BYTES);
            end
            vrsd_pkg::FS_DATA:
            begin
                kind = vrsd_pkg::KIND_DATA;
                size = 32'(acc_reg);
            end
            default:
            begin
                kind = vrsd_pkg::KIND_NLEN;
                size = 32'(vrsd_pkg::LEN_FIELD_BYTES);
            end
        endcase

        last     = ({1'b0, pos_reg} + 33'd1) >= {1'b0, size};
        len_over = ({1'b0, after} + 33'(acc_next)) > {1'b0, buffer_length};

        rec_end     = 1'b0;
        field_after = field_reg;
        case (field_reg)
            vrsd_pkg::FS_NLEN:
                field_after = (acc_next != '0) ? vrsd_pkg::FS_NAME : vrsd_pkg::FS_ID;
            vrsd_pkg::FS_NAME: field_after = vrsd_pkg::FS_ID;
            vrsd_pkg::FS_ID:   field_after = vrsd_pkg::FS_ATTR;
            vrsd_pkg::FS_ATTR: field_after = vrsd_pkg::FS_DLEN;
            vrsd_pkg::FS_DLEN:
            begin
                rec_end     = last && (acc_next == '0);
                field_after = (acc_next == '0) ? vrsd_pkg::FS_NLEN : vrsd_pkg::FS_DATA;
            end
            vrsd_pkg::FS_DATA:
            begin
                rec_end     = last;
                field_after = vrsd_pkg::FS_NLEN;
            end
            default: field_after = vrsd_pkg::FS_NLEN;
        endcase

        buf_end  = after == buffer_length;
        err_next = err_reg | (last && is_len && len_over) | (buf_end && !rec_end);

        field_next    = last ? field_after : field_reg;
        pos_next      = last ? 32'd0 : pos_reg + 32'd1;
        name_len_next = (last && field_reg == vrsd_pkg::FS_NLEN) ? acc_next : name_len_reg;
        consumed_next = after;
        rec_cnt_next  = (rec_end && rec_cnt_reg != '1) ? rec_cnt_reg + 32'd1 : rec_cnt_reg;

        result.byte_value    = item_byte;
        result.record_number = rec_cnt_reg;
        if (past_end)
        begin
            result.field_kind       = vrsd_pkg::KIND_NLEN;
            result.field_byte_index = 32'd0;
            result.record_end       = 1'b0;
            result.buffer_end       = 1'b0;
            result.parse_status     = err_reg ? vrsd_pkg::STATUS_ERROR : vrsd_pkg::STATUS_DONE;
        end
        else
        begin
            result.field_kind       = kind;
            result.field_byte_index = pos_reg;
            result.record_end       = rec_end;
            result.buffer_end       = buf_end;
            if (err_next)
                result.parse_status = vrsd_pkg::STATUS_ERROR;
            else if (buf_end)
                result.parse_status = vrsd_pkg::STATUS_DONE;
            else
                result.parse_status = vrsd_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            consumed_reg <= '0;
            field_reg    <= vrsd_pkg::FS_NLEN;
            pos_reg      <= '0;
            acc_reg      <= '0;
            name_len_reg <= '0;
            rec_cnt_reg  <= '0;
            err_reg      <= 1'b0;
        end
        else if (commit && !past_end)
        begin
            consumed_reg <= consumed_next;
            field_reg    <= field_next;
            pos_reg      <= pos_next;
            acc_reg      <= acc_next;
            name_len_reg <= name_len_next;
            rec_cnt_reg  <= rec_cnt_next;
            err_reg      <= err_next;
        end
    end

endmodule
